>>> rtl/vrc_pkg.sv
package vrc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAST_MAX   = 2'd2;

  localparam int SAMPLE_W = 32;
  localparam int SCALE_W  = 32;
  localparam int PROD_W   = 64;
  localparam int FRAC_DROP = 20;           // Q16.16 * Q16.16 -> Q.12
  localparam int Q12_W    = PROD_W - FRAC_DROP;
  localparam int COL_W    = 13;            // clamped colour, 0..6144
  localparam int CH_W     = 8;

  // Colour breakpoints, Q.12
  localparam logic [COL_W-1:0] COL_EIGHTH     = 13'd512;
  localparam logic [COL_W-1:0] COL_3_EIGHTHS  = 13'd1536;
  localparam logic [COL_W-1:0] COL_5_EIGHTHS  = 13'd2560;
  localparam logic [COL_W-1:0] COL_7_EIGHTHS  = 13'd3584;
  localparam logic [COL_W-1:0] COL_ONE        = 13'd4096;
  localparam logic [COL_W-1:0] COL_9_EIGHTHS  = 13'd4608;
  localparam logic [COL_W-1:0] COL_5_QUARTERS = 13'd5120;
  localparam logic [COL_W-1:0] COL_MAX        = 13'd6144;

  localparam logic [CH_W-1:0] CH_FULL  = 8'd255;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'd0;
  localparam logic [CH_W-1:0] DARK_RED = 8'd128;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // floor(d * 1020 / 4096), low 8 bits; 1020*d = 1024*d - 4*d
  function automatic logic [CH_W-1:0] ramp(input logic [COL_W-1:0] d);
    logic [COL_W+9:0] p;
    p = ({10'd0, d} << 10) - ({10'd0, d} << 2);
    return p[19:12];
  endfunction

endpackage

>>> rtl/vrc_map.sv
module vrc_map (
  input  logic [vrc_pkg::COL_W-1:0] col,
  input  logic                      past_max,
  output vrc_pkg::rgb_t             rgb
);
  import vrc_pkg::*;

  // Piecewise-linear jet segments, selected by colour
  always_comb begin
    rgb = '{red: CH_ZERO, green: CH_ZERO, blue: CH_ZERO};
    if (col < COL_EIGHTH) begin
      rgb.blue = ramp(col + COL_EIGHTH);
    end else if (col < COL_3_EIGHTHS) begin
      rgb.green = ramp(col - COL_EIGHTH);
      rgb.blue  = CH_FULL;
    end else if (col < COL_5_EIGHTHS) begin
      rgb.red   = ramp(col - COL_3_EIGHTHS);
      rgb.green = CH_FULL;
      rgb.blue  = ramp(COL_5_EIGHTHS - col);
    end else if (col < COL_7_EIGHTHS) begin
      rgb.red   = CH_FULL;
      rgb.green = ramp(COL_7_EIGHTHS - col);
    end else if (col < COL_ONE) begin
      rgb.red = ramp(COL_9_EIGHTHS - col);
    end else if (past_max) begin
      // beyond max: magenta, pink, white
      if (col < COL_9_EIGHTHS) begin
        rgb.red  = ramp(col - COL_7_EIGHTHS);
        rgb.blue = ramp(col - COL_ONE);
      end else if (col < COL_5_QUARTERS) begin
        rgb.red  = CH_FULL;
        rgb.blue = ramp(col - COL_ONE);
      end else if (col < COL_MAX) begin
        rgb.red   = CH_FULL;
        rgb.green = ramp(col - COL_5_QUARTERS);
        rgb.blue  = CH_FULL;
      end else begin
        rgb = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL};
      end
    end else begin
      rgb.red = DARK_RED;
    end
  end

endmodule

>>> rtl/value_to_rgb_colormap_core.sv
// Channel  | Signals                                | Direction
// ---------+----------------------------------------+----------
// input    | in_valid, in_ready, sample             | in
// output   | out_valid, out_ready, red, green, blue | out
// config   | cfg_we, cfg_index, cfg_data            | in
//
// Three register stages: sample register, product register, pixel register.
// A result moves through the sample, product and pixel registers in turn; one request per cycle
// unless a stalled output has filled every stage. The 32x32 normalizing multiply sets the product
// stage; the map sets the last. Synchronous reset clears the stage valids and loads the register defaults.
// A stalled output holds; earlier stages keep filling until every stage is full.
module value_to_rgb_colormap_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  input  logic                           cfg_we,
  input  logic [vrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import vrc_pkg::*;

  logic signed [SAMPLE_W-1:0] value_min;
  logic [SCALE_W-1:0]         norm_scale;
  logic                       past_max;

  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       s2_valid;
  logic [PROD_W-1:0]          s2_prod;
  rgb_t                       pix;

  logic s1_ready, s2_ready, s3_ready;
  logic [SAMPLE_W:0]          diff;
  logic                       diff_pos;
  logic [PROD_W-1:0]          prod_next;
  logic [Q12_W-1:0]           q12;
  logic [COL_W-1:0]           col;
  rgb_t                       rgb_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      value_min  <= '0;
      norm_scale <= SCALE_W'(65536);
      past_max   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VALUE_MIN:  value_min  <= cfg_data;
        CFG_NORM_SCALE: norm_scale <= cfg_data;
        CFG_PAST_MAX:   past_max   <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Per-stage ready chain
  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Stage 2 logic: exact 33-bit difference, product only when positive
  assign diff      = {s1_sample[SAMPLE_W-1], s1_sample} - {value_min[SAMPLE_W-1], value_min};
  assign diff_pos  = !diff[SAMPLE_W] && (diff[SAMPLE_W-1:0] != '0);
  assign prod_next = diff_pos ? (PROD_W'(diff[SAMPLE_W-1:0]) * PROD_W'(norm_scale)) : '0;

  // Stage 3 logic: truncate to Q.12, clamp, map
  assign q12 = s2_prod[PROD_W-1:FRAC_DROP];
  assign col = (q12 > Q12_W'(COL_MAX)) ? COL_MAX : q12[COL_W-1:0];

  vrc_map u_map (
    .col      (col),
    .past_max (past_max),
    .rgb      (rgb_next)
  );

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= in_valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) out_valid <= s2_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1_sample <= sample;
    if (s2_ready && s1_valid) s2_prod   <= prod_next;
    if (s3_ready && s2_valid) pix       <= rgb_next;
  end

  assign red   = pix.red;
  assign green = pix.green;
  assign blue  = pix.blue;

endmodule

>>> rtl/vrc_checker.sv
module vrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // a result waiting to be taken stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its pixel
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled pixel changed");

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // an empty output register never blocks new requests
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind value_to_rgb_colormap_core vrc_checker u_vrc_checker (.*);

>>> verif/tb_value_to_rgb_colormap_core.sv
module tb_value_to_rgb_colormap_core;
  import vrc_pkg::*;

  // write to this index must be dropped by the block
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int LONG_HOLD = 60;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [31:0]    sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_data;

  // Expected pixels in request order, plus a private copy of the registers
  class pixel_scoreboard;
    logic signed [31:0] value_min;
    logic [31:0]        norm_scale;
    logic               past_max;
    rgb_t               pixels_due[$];
    int                 errors;
    int                 n_requests;
    int                 n_pixels;

    function new();
      value_min  = '0;
      norm_scale = 32'd65536;
      past_max   = 1'b1;
      errors     = 0;
      n_requests = 0;
      n_pixels   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_VALUE_MIN:  value_min  = d;
        CFG_NORM_SCALE: norm_scale = d;
        CFG_PAST_MAX:   past_max   = d[0];
        default: ;
      endcase
    endfunction

    // floor(d * 1020 / 4096), low byte
    function logic [7:0] channel_ramp(logic [12:0] d);
      logic [31:0] t;
      t = d * 32'd1020;
      return t[19:12];
    endfunction

    function rgb_t map_sample(logic signed [31:0] s);
      longint      diff;
      logic [63:0] prod;
      logic [12:0] c;
      rgb_t        px;
      diff = longint'(s) - longint'(value_min);
      c = '0;
      // normalize: exact product, drop 20 fraction bits, clamp to 1.5
      if (diff > 0) begin
        prod = 64'(diff) * {32'd0, norm_scale};
        prod = prod >> 20;
        c = (prod > 64'(COL_MAX)) ? COL_MAX : prod[12:0];
      end
      px = '0;
      if (c < COL_EIGHTH) begin
        px.blue = channel_ramp(c + COL_EIGHTH);
      end else if (c < COL_3_EIGHTHS) begin
        px.green = channel_ramp(c - COL_EIGHTH);
        px.blue  = 8'd255;
      end else if (c < COL_5_EIGHTHS) begin
        px.red   = channel_ramp(c - COL_3_EIGHTHS);
        px.green = 8'd255;
        px.blue  = channel_ramp(COL_5_EIGHTHS - c);
      end else if (c < COL_7_EIGHTHS) begin
        px.red   = 8'd255;
        px.green = channel_ramp(COL_7_EIGHTHS - c);
      end else if (c < COL_ONE) begin
        px.red = channel_ramp(COL_9_EIGHTHS - c);
      end else if (past_max) begin
        // beyond max: magenta, pink, then white
        if (c < COL_9_EIGHTHS) begin
          px.red  = channel_ramp(c - COL_7_EIGHTHS);
          px.blue = channel_ramp(c - COL_ONE);
        end else if (c < COL_5_QUARTERS) begin
          px.red  = 8'd255;
          px.blue = channel_ramp(c - COL_ONE);
        end else if (c < COL_MAX) begin
          px.red   = 8'd255;
          px.green = channel_ramp(c - COL_5_QUARTERS);
          px.blue  = 8'd255;
        end else begin
          px = '{8'd255, 8'd255, 8'd255};
        end
      end else begin
        px.red = DARK_RED;
      end
      return px;
    endfunction

    function void note_request(logic signed [31:0] s);
      pixels_due.insert(pixels_due.size(), map_sample(s));
      n_requests++;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_channel(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("pixel %0d %s got %0d want %0d", n_pixels, name, got, want));
    endtask

    task check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel (%0d,%0d,%0d) with no request pending", r, g, b));
      end else begin
        want = pixels_due.pop_front();
        check_channel("red", r, want.red);
        check_channel("green", g, want.green);
        check_channel("blue", b, want.blue);
      end
      n_pixels++;
    endtask
  endclass

  pixel_scoreboard sb = new();

  bit tx_gaps;
  bit rx_gaps;
  bit long_hold_req;
  bit valid_up;
  int n_settings;

  value_to_rgb_colormap_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one; never zero
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Aim at a chosen colour under the current registers; some fully random
  function automatic logic [31:0] aim_sample();
    longint aim;
    longint c_t;
    if (sb.norm_scale == 0 || $urandom_range(0, 3) == 0) return $urandom;
    c_t = $urandom_range(0, 6400);
    aim = longint'(sb.value_min)
        + ((c_t << 20) + longint'($urandom_range(0, 1048575)))
          / longint'({32'd0, sb.norm_scale});
    if (aim > 64'sh7FFF_FFFF) aim = 64'sh7FFF_FFFF;
    return aim[31:0];
  endfunction

  // Offer one request and hold it until accepted
  task send_sample(input logic [31:0] s);
    in_valid <= 1'b1;
    sample   <= s;
    valid_up = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(s);
    if (tx_gaps && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every pixel to come back
  task wait_drained();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task program_cfg(input logic [31:0] vmin, input logic [31:0] scale,
                   input logic [31:0] pm_word);
    put_reg(CFG_VALUE_MIN, vmin);
    put_reg(CFG_NORM_SCALE, scale);
    put_reg(CFG_PAST_MAX, pm_word);
    put_reg(CFG_UNUSED_IDX, $urandom);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // First half back to back, second half with gaps on both sides
  task run_phase(input int n, input bit squeeze);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    if (squeeze) long_hold_req = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) begin
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
      end
      send_sample(aim_sample());
    end
    wait_drained();
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_pixel(red, green, blue);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        hold_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [12:0] edge_cols [18];
    edge_cols = '{13'd0, 13'd511, 13'd512, 13'd1535, 13'd1536, 13'd2559,
                  13'd2560, 13'd3583, 13'd3584, 13'd4095, 13'd4096, 13'd4607,
                  13'd4608, 13'd5119, 13'd5120, 13'd6143, 13'd6144, 13'd6145};
    in_valid  <= 1'b0;
    sample    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst       <= 1'b1;
    valid_up = 1'b0;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    long_hold_req = 1'b0;
    n_settings = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: colour is sample/16, so hit every segment boundary
    foreach (edge_cols[i]) send_sample({15'd0, edge_cols[i], 4'd0});
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    wait_drained();

    // defaults rewritten, junk above past_max bit
    program_cfg(32'd0, 32'd65536, 32'hFFFF_FFFF);
    run_phase(60, 1'b1);
    // widest range, largest scale, dark red above max
    program_cfg(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    run_phase(60, 1'b0);
    // minimum at the top: nearly all samples at or below it
    program_cfg(32'h7FFF_FFFF, 32'd65536, 32'd1);
    run_phase(50, 1'b0);
    // zero scale
    program_cfg($urandom, 32'd0, $urandom);
    run_phase(50, 1'b0);
    program_cfg($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                $urandom_range(256, 32'h0100_0000), $urandom);
    run_phase(80, 1'b1);
    program_cfg($urandom, $urandom, 32'd0);
    run_phase(80, 1'b0);

    repeat (10) @(posedge clk);
    $display("Summary: %0d samples mapped, %0d pixels checked, %0d register settings",
             sb.n_requests, sb.n_pixels, n_settings);
    $display("Covered segment edges, zero and full scale, range extremes, both max modes");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule
